// ===== hdl/krl_pkg.sv =====
package krl_pkg;

  localparam int unsigned KeyW  = 16;
  localparam int unsigned CoolW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned WinW  = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic KindCheck  = 1'b0;
  localparam logic KindRecord = 1'b1;

  localparam logic [CfgIdxW-1:0] RegEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMax    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWindow = 2'd2;

  localparam logic [2:0] VerdictAllowed  = 3'd0;
  localparam logic [2:0] VerdictDisabled = 3'd1;
  localparam logic [2:0] VerdictLimit    = 3'd2;
  localparam logic [2:0] VerdictFull     = 3'd3;
  localparam logic [2:0] VerdictCooldown = 3'd4;
  localparam logic [2:0] VerdictRecorded = 3'd5;

  typedef struct packed {
    logic             kind;
    logic [KeyW-1:0]  key_id;
    logic [CoolW-1:0] cooldown;
    logic [TimeW-1:0] now;
  } req_t;

  typedef struct packed {
    logic tok;
    logic hit;
    logic cool;
  } link_t;

endpackage

// ===== hdl/krl_cell.sv =====
module krl_cell #(
  parameter int unsigned ENTRIES  = 32,
  parameter int unsigned KEY_BITS = 16,
  parameter int unsigned IDX      = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  krl_pkg::req_t                    req_i,
  input  krl_pkg::link_t                   link_i,
  output krl_pkg::link_t                   link_o,
  input  logic                             alloc_i,
  input  logic [$clog2(ENTRIES+1)-1:0]     used_i
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned KW = (KEY_BITS < krl_pkg::KeyW) ? KEY_BITS : krl_pkg::KeyW;
  localparam logic [CntW-1:0] MyIdx = CntW'(IDX);

  logic [KW-1:0]                key_q;
  logic [krl_pkg::TimeW-1:0]    time_q;
  logic                         stamped_q;
  krl_pkg::link_t               link_d, link_q;
  logic                         active, match, cool_run, alloc_here;
  logic [krl_pkg::TimeW-1:0]    elapsed;

  assign active     = MyIdx < used_i;
  assign match      = link_i.tok && !link_i.hit && active &&
                      (key_q == req_i.key_id[KW-1:0]);
  assign elapsed    = req_i.now - time_q;
  assign cool_run   = stamped_q &&
                      (elapsed < {{(krl_pkg::TimeW-krl_pkg::CoolW){1'b0}}, req_i.cooldown});
  assign alloc_here = alloc_i && (used_i == MyIdx);

  always_comb begin
    link_d.tok  = link_i.tok;
    link_d.hit  = link_i.hit | match;
    link_d.cool = match ? cool_run : link_i.cool;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q <= link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_here) begin
      key_q     <= req_i.key_id[KW-1:0];
      time_q    <= req_i.now;
      stamped_q <= req_i.kind;
    end else if (match && (req_i.kind == krl_pkg::KindRecord)) begin
      time_q    <= req_i.now;
      stamped_q <= 1'b1;
    end
  end

  assign link_o = link_q;

endmodule

// ===== hdl/keyed_cooldown_rate_limiter_core.sv =====
// Keyed cooldown rate limiter.
// A request is accepted when start_i is high and busy_o is low. kind_i selects a check
// or a record; key_id_i, cooldown_length_i and now_i travel with it. Every request
// gives exactly one result on allowed_o and verdict_o, marked by valid_o for one cycle.
// The receiver cannot stall; a result is shown once and the next request may be
// accepted in the same cycle that the result is shown.
// A disabled check or a check over the window limit answers straight from the evaluate state.
// Every other request sends a search token down a row of ENTRIES key cells, one cell
// per cycle, answers once the token leaves the last cell, and the next request can
// follow right away.
// Configuration writes use cfg_valid_i, cfg_ready_o (always high), cfg_index_i and
// cfg_data_i. Users must make writes only while busy_o is low; it is not enforced.
// Reset empties the key table by clearing its fill count, zeroes the window count and
// window start, and loads the registers with enabled, a limit of ten and a window of
// 3600 seconds. No clearing pass is needed.
module keyed_cooldown_rate_limiter_core #(
  parameter int unsigned ENTRIES  = 32,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           kind_i,
  input  logic [krl_pkg::KeyW-1:0]       key_id_i,
  input  logic [krl_pkg::CoolW-1:0]      cooldown_length_i,
  input  logic [krl_pkg::TimeW-1:0]      now_i,
  output logic                           valid_o,
  output logic                           allowed_o,
  output logic [2:0]                     verdict_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [krl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [krl_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StEval   = 2'd1;
  localparam logic [1:0] StSearch = 2'd2;

  logic [1:0]                    state_q, state_d;
  krl_pkg::req_t                 req_q;
  logic                          enabled_q;
  logic [krl_pkg::CountW-1:0]    max_q;
  logic [krl_pkg::WinW-1:0]      win_len_q;
  logic [CntW-1:0]               used_q, used_d;
  logic [krl_pkg::CountW-1:0]    count_q, count_d;
  logic [krl_pkg::TimeW-1:0]     win_start_q, win_start_d;
  logic                          valid_q, valid_d;
  logic                          allowed_q, allowed_d;
  logic [2:0]                    verdict_q, verdict_d;
  logic                          inject, alloc;
  logic                          expired, full;
  logic [krl_pkg::TimeW-1:0]     win_age;
  logic [krl_pkg::CountW-1:0]    count_eff;
  krl_pkg::link_t                links [ENTRIES+1];

  assign busy_o      = state_q != StIdle;
  assign cfg_ready_o = 1'b1;
  assign valid_o     = valid_q;
  assign allowed_o   = allowed_q;
  assign verdict_o   = verdict_q;

  assign win_age   = req_q.now - win_start_q;
  assign expired   = win_age >= {{(krl_pkg::TimeW-krl_pkg::WinW){1'b0}}, win_len_q};
  assign count_eff = expired ? '0 : count_q;
  assign full      = used_q == CntW'(ENTRIES);

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    count_d     = count_q;
    win_start_d = win_start_q;
    valid_d     = 1'b0;
    allowed_d   = 1'b0;
    verdict_d   = krl_pkg::VerdictAllowed;
    inject      = 1'b0;
    alloc       = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StEval;
        end
      end
      StEval: begin
        if (req_q.kind == krl_pkg::KindRecord) begin
          inject  = 1'b1;
          state_d = StSearch;
        end else if (!enabled_q) begin
          valid_d   = 1'b1;
          verdict_d = krl_pkg::VerdictDisabled;
          state_d   = StIdle;
        end else begin
          if (expired) begin
            count_d     = '0;
            win_start_d = req_q.now;
          end
          if (count_eff >= max_q) begin
            valid_d   = 1'b1;
            verdict_d = krl_pkg::VerdictLimit;
            state_d   = StIdle;
          end else begin
            inject  = 1'b1;
            state_d = StSearch;
          end
        end
      end
      StSearch: begin
        if (links[ENTRIES].tok) begin
          valid_d = 1'b1;
          state_d = StIdle;
          if (!links[ENTRIES].hit && !full) begin
            alloc  = 1'b1;
            used_d = used_q + 1'b1;
          end
          if (req_q.kind == krl_pkg::KindRecord) begin
            verdict_d = krl_pkg::VerdictRecorded;
            if (count_q != '1) begin
              count_d = count_q + 1'b1;
            end
          end else if (!links[ENTRIES].hit && full) begin
            verdict_d = krl_pkg::VerdictFull;
          end else if (links[ENTRIES].hit && links[ENTRIES].cool) begin
            verdict_d = krl_pkg::VerdictCooldown;
          end else begin
            verdict_d = krl_pkg::VerdictAllowed;
            allowed_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      used_q      <= '0;
      count_q     <= '0;
      win_start_q <= '0;
      valid_q     <= 1'b0;
      enabled_q   <= 1'b1;
      max_q       <= krl_pkg::CountW'(10);
      win_len_q   <= krl_pkg::WinW'(3600);
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      count_q     <= count_d;
      win_start_q <= win_start_d;
      valid_q     <= valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          krl_pkg::RegEnable: enabled_q <= cfg_data_i[0];
          krl_pkg::RegMax:    max_q     <= cfg_data_i[krl_pkg::CountW-1:0];
          krl_pkg::RegWindow: win_len_q <= cfg_data_i[krl_pkg::WinW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    allowed_q <= allowed_d;
    verdict_q <= verdict_d;
    if ((state_q == StIdle) && start_i) begin
      req_q.kind     <= kind_i;
      req_q.key_id   <= key_id_i;
      req_q.cooldown <= cooldown_length_i;
      req_q.now      <= now_i;
    end
  end

  always_comb begin
    links[0].tok  = inject;
    links[0].hit  = 1'b0;
    links[0].cool = 1'b0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    krl_cell #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS),
      .IDX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .req_i   (req_q),
      .link_i  (links[i]),
      .link_o  (links[i+1]),
      .alloc_i (alloc),
      .used_i  (used_q)
    );
  end

endmodule

// ===== tb/tb_keyed_cooldown_rate_limiter_core.sv =====
module tb_keyed_cooldown_rate_limiter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = 32;
  localparam int PoolSize = 40;
  localparam int QuietLimit = 4000;

  typedef enum logic {
    OpRequest,
    OpRegWrite
  } op_e;

  typedef struct packed {
    op_e                                op;
    logic                               kind;
    logic [krl_pkg::KeyW-1:0]           key;
    logic [krl_pkg::CoolW-1:0]          cool;
    logic [krl_pkg::TimeW-1:0]          now;
    logic [krl_pkg::CfgIdxW-1:0]        idx;
    logic [krl_pkg::CfgDataW-1:0]       data;
    logic [2:0]                         gap;
  } op_t;

  typedef struct packed {
    logic       allowed;
    logic [2:0] verdict;
  } answer_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start_i = 1'b0;
  logic                          busy_o;
  logic                          kind_i = 1'b0;
  logic [krl_pkg::KeyW-1:0]      key_id_i = '0;
  logic [krl_pkg::CoolW-1:0]     cooldown_length_i = '0;
  logic [krl_pkg::TimeW-1:0]     now_i = '0;
  logic                          valid_o;
  logic                          allowed_o;
  logic [2:0]                    verdict_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [krl_pkg::CfgIdxW-1:0]   cfg_index_i = '0;
  logic [krl_pkg::CfgDataW-1:0]  cfg_data_i = '0;

  keyed_cooldown_rate_limiter_core #(
    .ENTRIES  (Slots),
    .KEY_BITS (16)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .kind_i            (kind_i),
    .key_id_i          (key_id_i),
    .cooldown_length_i (cooldown_length_i),
    .now_i             (now_i),
    .valid_o           (valid_o),
    .allowed_o         (allowed_o),
    .verdict_o         (verdict_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // Shadow of the limiter state.
  logic                         en_reg = 1'b1;
  logic [krl_pkg::CountW-1:0]   max_reg = 16'd10;
  logic [krl_pkg::WinW-1:0]     win_len = 17'd3600;
  logic [krl_pkg::KeyW-1:0]     slot_key [Slots];
  logic [krl_pkg::TimeW-1:0]    slot_time [Slots];
  logic                         slot_stamped [Slots];
  int                           slots_used = 0;
  logic [krl_pkg::CountW-1:0]   win_count = '0;
  logic [krl_pkg::TimeW-1:0]    win_start = '0;

  op_t     op_q[$];
  answer_t verdict_q[$];

  int sent_cnt = 0;
  int done_cnt = 0;
  int reg_writes = 0;
  int err_cnt = 0;
  int gap_left = 0;
  int quiet = 0;
  int verdict_tally [8];

  logic                       idle_on = 1'b1;
  logic [krl_pkg::TimeW-1:0]  sim_now = '0;
  logic [krl_pkg::KeyW-1:0]   key_pool [PoolSize];

  function automatic int claim_slot(input logic [krl_pkg::KeyW-1:0] key);
    for (int i = 0; i < slots_used; i++) begin
      if (slot_key[i] == key) return i;
    end
    if (slots_used >= Slots) return -1;
    slot_key[slots_used] = key;
    slot_time[slots_used] = '0;
    slot_stamped[slots_used] = 1'b0;
    slots_used++;
    return slots_used - 1;
  endfunction

  function automatic answer_t judge_request(input op_t r);
    answer_t a;
    int slot;
    logic [krl_pkg::TimeW-1:0] age;
    a.allowed = 1'b0;
    a.verdict = krl_pkg::VerdictAllowed;
    if (r.kind == krl_pkg::KindRecord) begin
      slot = claim_slot(r.key);
      if (slot >= 0) begin
        slot_time[slot] = r.now;
        slot_stamped[slot] = 1'b1;
      end
      if (win_count != 16'hFFFF) win_count = win_count + 1'b1;
      a.verdict = krl_pkg::VerdictRecorded;
    end else if (!en_reg) begin
      a.verdict = krl_pkg::VerdictDisabled;
    end else begin
      age = r.now - win_start;
      if (age >= {15'd0, win_len}) begin
        win_count = '0;
        win_start = r.now;
      end
      if (win_count >= max_reg) begin
        a.verdict = krl_pkg::VerdictLimit;
      end else begin
        slot = claim_slot(r.key);
        if (slot < 0) begin
          a.verdict = krl_pkg::VerdictFull;
        end else begin
          age = r.now - slot_time[slot];
          if (slot_stamped[slot] && age < {16'd0, r.cool}) begin
            a.verdict = krl_pkg::VerdictCooldown;
          end else begin
            a.verdict = krl_pkg::VerdictAllowed;
            a.allowed = 1'b1;
          end
        end
      end
    end
    return a;
  endfunction

  task automatic add_request(input logic kind, input logic [krl_pkg::KeyW-1:0] key,
                             input logic [krl_pkg::CoolW-1:0] cool,
                             input logic [krl_pkg::TimeW-1:0] now);
    op_t r;
    r = '0;
    r.op = OpRequest;
    r.kind = kind;
    r.key = key;
    r.cool = cool;
    r.now = now;
    if (idle_on && $urandom_range(0, 3) == 0) r.gap = 3'($urandom_range(1, 7));
    op_q.push_back(r);
  endtask

  task automatic add_write(input logic [krl_pkg::CfgIdxW-1:0] idx,
                           input logic [krl_pkg::CfgDataW-1:0] value);
    op_t r;
    logic [krl_pkg::CfgDataW-1:0] mask;
    logic [krl_pkg::CfgDataW-1:0] junk;
    r = '0;
    case (idx)
      krl_pkg::RegEnable: mask = 32'h1;
      krl_pkg::RegMax:    mask = 32'hFFFF;
      default:            mask = 32'h1FFFF;
    endcase
    junk = ($urandom_range(0, 3) == 0) ? $urandom : '0;
    r.op = OpRegWrite;
    r.idx = idx;
    r.data = (junk & ~mask) | (value & mask);
    op_q.push_back(r);
  endtask

  task automatic run_phase(input logic en, input logic [krl_pkg::CountW-1:0] lim,
                           input logic [krl_pkg::WinW-1:0] win, input int items,
                           input logic idles);
    int n;
    int pick;
    logic [krl_pkg::KeyW-1:0] key;
    logic [krl_pkg::CoolW-1:0] cool;
    add_write(krl_pkg::RegEnable, {31'd0, en});
    add_write(krl_pkg::RegMax, {16'd0, lim});
    add_write(krl_pkg::RegWindow, {15'd0, win});
    idle_on = idles;
    n = 0;
    while (n < items) begin
      if (idles && $urandom_range(0, 29) == 0) idle_on = !idle_on;
      pick = $urandom_range(0, 99);
      if (pick < 80) sim_now = sim_now + $urandom_range(0, 30);
      else if (pick < 90) sim_now = sim_now + $urandom_range(0, 2000);
      else if (pick < 95) sim_now = $urandom;
      else sim_now = sim_now - $urandom_range(0, 100);
      key = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, PoolSize - 1)]
                                        : 16'($urandom);
      pick = $urandom_range(0, 9);
      cool = (pick < 7) ? 16'($urandom_range(0, 400)) :
             (pick < 9) ? 16'($urandom_range(0, 50)) : 16'($urandom);
      if ($urandom_range(0, 9) < 4) begin
        // A check followed by the record that normally acts on it.
        add_request(krl_pkg::KindCheck, key, cool, sim_now);
        sim_now = sim_now + $urandom_range(0, 3);
        add_request(krl_pkg::KindRecord, key, 16'($urandom), sim_now);
        n += 2;
      end else begin
        add_request(($urandom_range(0, 99) < 55) ? krl_pkg::KindCheck : krl_pkg::KindRecord,
                    key, cool, sim_now);
        n++;
      end
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : drive
    op_t head;
    answer_t want;
    logic hold;
    logic go_start;
    logic go_cfg;
    int open_cnt;
    if (!rst_ni) begin
      start_i <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        head = op_q.pop_front();
        want = judge_request(head);
        verdict_q.push_back(want);
        sent_cnt++;
        gap_left = (op_q.size() != 0) ? int'(op_q[0].gap) : 0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        head = op_q.pop_front();
        case (head.idx)
          krl_pkg::RegEnable: en_reg = head.data[0];
          krl_pkg::RegMax:    max_reg = head.data[15:0];
          default:            win_len = head.data[16:0];
        endcase
        reg_writes++;
        gap_left = (op_q.size() != 0) ? int'(op_q[0].gap) : 0;
      end
      hold = (start_i && busy_o) || (cfg_valid_i && !cfg_ready_o);
      open_cnt = sent_cnt - done_cnt - int'(valid_o);
      go_start = 1'b0;
      go_cfg = 1'b0;
      if (hold) begin
        go_start = start_i;
        go_cfg = cfg_valid_i;
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (op_q.size() != 0) begin
        head = op_q[0];
        if (head.op == OpRequest) begin
          go_start = 1'b1;
          kind_i <= head.kind;
          key_id_i <= head.key;
          cooldown_length_i <= head.cool;
          now_i <= head.now;
        end else if (open_cnt == 0 && !busy_o) begin
          go_cfg = 1'b1;
          cfg_index_i <= head.idx;
          cfg_data_i <= head.data;
        end
      end
      start_i <= go_start;
      cfg_valid_i <= go_cfg;
    end
  end

  always @(posedge clk_i) begin : watch_results
    answer_t want;
    if (rst_ni && valid_o) begin
      done_cnt <= done_cnt + 1;
      verdict_tally[verdict_o]++;
      if (verdict_q.size() == 0) begin
        $display("%0t: result with no request pending, actual allowed %0b verdict %0d",
                 $time, allowed_o, verdict_o);
        err_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (allowed_o !== want.allowed) begin
          $display("%0t: allowed mismatch, expected %0b actual %0b",
                   $time, want.allowed, allowed_o);
          err_cnt++;
        end
        if (verdict_o !== want.verdict) begin
          $display("%0t: verdict mismatch, expected %0d actual %0d",
                   $time, want.verdict, verdict_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((start_i && !busy_o) || valid_o || (cfg_valid_i && cfg_ready_o)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("%0t: no progress for %0d cycles", $time, quiet);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    foreach (verdict_tally[i]) verdict_tally[i] = 0;
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < PoolSize; i++) key_pool[i] = 16'($urandom);

    // Directed requests, first under the reset settings and then around register writes.
    add_request(krl_pkg::KindCheck, 16'h0000, 16'h0000, 32'd0);
    add_request(krl_pkg::KindCheck, 16'h0000, 16'hFFFF, 32'd0);
    add_request(krl_pkg::KindRecord, 16'h0000, 16'h0000, 32'd0);
    add_request(krl_pkg::KindCheck, 16'h0000, 16'd5, 32'd3);
    add_request(krl_pkg::KindCheck, 16'h0000, 16'd5, 32'd5);
    add_request(krl_pkg::KindCheck, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_request(krl_pkg::KindRecord, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_request(krl_pkg::KindCheck, 16'hFFFF, 16'd2, 32'd0);
    add_request(krl_pkg::KindCheck, 16'hFFFF, 16'd1, 32'd0);
    add_write(krl_pkg::RegMax, 32'd2);
    add_request(krl_pkg::KindRecord, 16'h0000, 16'd0, 32'd10);
    add_request(krl_pkg::KindCheck, 16'h1234, 16'd0, 32'd10);
    add_write(krl_pkg::RegEnable, 32'd0);
    add_request(krl_pkg::KindCheck, 16'h0000, 16'd0, 32'd20);
    add_request(krl_pkg::KindRecord, 16'h5A5A, 16'd0, 32'd20);
    add_write(krl_pkg::RegEnable, 32'd1);
    add_write(krl_pkg::RegWindow, 32'd0);
    add_request(krl_pkg::KindCheck, 16'h0000, 16'd0, 32'd20);
    add_request(krl_pkg::KindRecord, 16'h0000, 16'd0, 32'd21);
    add_request(krl_pkg::KindRecord, 16'h0000, 16'd0, 32'd21);
    add_request(krl_pkg::KindCheck, 16'h0000, 16'd0, 32'd21);
    add_write(krl_pkg::RegMax, 32'd0);
    add_request(krl_pkg::KindCheck, 16'h0000, 16'd0, 32'd22);
    add_write(krl_pkg::RegMax, 32'd65535);
    add_write(krl_pkg::RegWindow, 32'h1FFFF);
    add_request(krl_pkg::KindCheck, 16'hA5A5, 16'h8000, 32'h8000_0000);
    add_request(krl_pkg::KindRecord, 16'hA5A5, 16'h8000, 32'h8000_0000);
    add_request(krl_pkg::KindCheck, 16'hA5A5, 16'h7FFF, 32'h8000_7FFE);

    sim_now = 32'h8000_8000;
    run_phase(1'b1, 16'd5, 17'd300, 350, 1'b1);
    run_phase(1'b1, 16'd65535, 17'd86400, 300, 1'b1);
    run_phase(1'b0, 16'd5, 17'd300, 150, 1'b1);
    run_phase(1'b1, 16'd0, 17'd1, 100, 1'b1);
    run_phase(1'b1, 16'd3, 17'd0, 150, 1'b1);
    run_phase(1'b1, 16'd20, 17'h1FFFF, 350, 1'b1);
    run_phase(1'b1, 16'd8, 17'd500, 300, 1'b0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_q.size() != 0 || verdict_q.size() != 0) @(posedge clk_i);
    repeat (Slots + 10) @(posedge clk_i);

    $display("Covered %0d requests and %0d register writes; %0d table slots filled.",
             done_cnt, reg_writes, slots_used);
    $display("Verdicts: allowed %0d, disabled %0d, limit %0d, full %0d,",
             verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3]);
    $display("  cooldown %0d, recorded %0d", verdict_tally[4], verdict_tally[5]);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
